// ===== src/ppm_pkg.sv =====
package ppm_pkg;

	localparam int PW_W      = 16;  // pulse width and register width
	localparam int PCT_W     = 14;  // percent field
	localparam int CHAN_W    = 4;   // channel field
	localparam int IDX_W     = 5;   // running channel index
	localparam int PROD_W    = PW_W + PCT_W;
	localparam int DIV_STEPS = PCT_W;
	localparam int STEP_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 3;

	localparam logic [PCT_W-1:0] FULL_SCALE = 14'd10000;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH      = 2'd2;

	localparam logic [PW_W-1:0] RST_SYNC_THRESHOLD = 16'd500;
	localparam logic [PW_W-1:0] RST_MIN_WIDTH      = 16'd60;
	localparam logic [PW_W-1:0] RST_MAX_WIDTH      = 16'd160;

	localparam logic FUNC_OVERFLOW = 1'b1;

	// Result flags decided by the controller and carried into the output beat.
	typedef struct packed {
		logic              value_valid;
		logic [CHAN_W-1:0] channel;
		logic              frame_end;
		logic              overrun_error;
		logic              synced;
		logic              pct_zero;
	} ppm_res_t;

	typedef struct packed {
		logic     load_in;
		logic     prep;
		logic     mul;
		logic     div_step;
		logic     out_load;
		ppm_res_t res;
	} ppm_cmd_t;

	typedef struct packed {
		logic is_overflow;
		logic is_sync;
		logic empty_range;
		logic out_free;
	} ppm_sts_t;

endpackage

// ===== src/ppm_ctrl.sv =====
module ppm_ctrl
	import ppm_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ppm_sts_t sts,
	output ppm_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_MUL    = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_DONE   = 5'b10000
	} ppm_state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS);

	ppm_state_t        state_q, state_d;
	logic              sync_q, sync_d;
	logic [IDX_W-1:0]  chan_q, chan_d;
	logic [STEP_W-1:0] step_q, step_d;
	ppm_res_t          res_q, res_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		sync_d  = sync_q;
		chan_d  = chan_q;
		step_d  = step_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.res = res_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.prep = 1'b1;
				res_d    = '0;
				state_d  = ST_DONE;
				if (sts.is_overflow) begin
					sync_d = 1'b0;
					chan_d = '0;
				end else if (sts.is_sync) begin
					sync_d          = 1'b1;
					chan_d          = '0;
					res_d.frame_end = 1'b1;
				end else if (!sync_q) begin
					// Short pulse before the first sync is ignored.
				end else if (chan_q >= LAST_IDX) begin
					sync_d              = 1'b0;
					chan_d              = '0;
					res_d.overrun_error = 1'b1;
				end else begin
					res_d.value_valid = 1'b1;
					res_d.channel     = chan_q[CHAN_W-1:0];
					res_d.pct_zero    = sts.empty_range;
					chan_d            = chan_q + 1'b1;
					if (!sts.empty_range) begin
						state_d = ST_MUL;
					end
				end
				res_d.synced = sync_d;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				step_d  = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sync_q  <= 1'b0;
			chan_q  <= '0;
			step_q  <= '0;
			res_q   <= '0;
		end else begin
			state_q <= state_d;
			sync_q  <= sync_d;
			chan_q  <= chan_d;
			step_q  <= step_d;
			res_q   <= res_d;
		end
	end

	// The running index never passes the channel count.
	a_chan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q <= LAST_IDX)
		else $error("channel index beyond channel count");

	// A pulse past the last channel of a synced frame drops sync.
	a_overrun_drops_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) && sync_q && !sts.is_overflow && !sts.is_sync
			&& (chan_q >= LAST_IDX) |=> !sync_q && res_q.overrun_error)
		else $error("overrun did not drop sync");

	// The divider runs only while its step count is in range.
	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (step_q < STEP_W'(DIV_STEPS)))
		else $error("divider step count out of range");

	// A value result is only ever reported while synced.
	a_value_synced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && res_q.value_valid |-> res_q.synced && sync_q)
		else $error("value reported while not synced");

endmodule

// ===== src/ppm_dpath.sv =====
module ppm_dpath
	import ppm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PW_W-1:0]       cfg_data,
	input  ppm_cmd_t              cmd,
	output ppm_sts_t              sts,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	logic [PW_W-1:0]   thr_q, lo_q, hi_q;
	logic              func_q;
	logic [PW_W-1:0]   pw_q;
	logic [PW_W-1:0]   diff_q, den_q;
	logic [PW_W-1:0]   rem_q;
	logic [PCT_W-1:0]  quo_q;
	logic              out_valid_q;
	logic [CHAN_W-1:0] out_chan_q;
	logic [PCT_W-1:0]  out_pct_q;
	logic              out_fend_q, out_vld_q, out_ovr_q, out_sync_q;

	logic [PW_W-1:0]   clamped;
	logic [PROD_W-1:0] prod;
	logic [PW_W:0]     trial;
	logic              trial_ge;

	assign sts.is_overflow = (func_q == FUNC_OVERFLOW);
	assign sts.is_sync     = (pw_q >= thr_q);
	assign sts.empty_range = (hi_q <= lo_q);
	assign sts.out_free    = !out_valid_q || m_axis_tready;

	always_comb begin
		clamped = pw_q;
		if (pw_q > hi_q) begin
			clamped = hi_q;
		end else if (pw_q < lo_q) begin
			clamped = lo_q;
		end
	end

	assign prod     = PROD_W'(diff_q) * PROD_W'(FULL_SCALE);
	assign trial    = {rem_q, quo_q[PCT_W-1]};
	assign trial_ge = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= RST_SYNC_THRESHOLD;
			lo_q        <= RST_MIN_WIDTH;
			hi_q        <= RST_MAX_WIDTH;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_SYNC_THRESHOLD: thr_q <= cfg_data;
					REG_MIN_WIDTH:      lo_q  <= cfg_data;
					REG_MAX_WIDTH:      hi_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= s_axis_tuser;
			pw_q   <= s_axis_tdata[PW_W-1:0];
		end
		if (cmd.prep) begin
			diff_q <= clamped - lo_q;
			den_q  <= hi_q - lo_q;
		end
		if (cmd.mul) begin
			// The quotient fits in PCT_W bits, so the upper part is already below den_q.
			rem_q <= prod[PROD_W-1:PCT_W];
			quo_q <= prod[PCT_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? PW_W'(trial - {1'b0, den_q}) : trial[PW_W-1:0];
			quo_q <= {quo_q[PCT_W-2:0], trial_ge};
		end
		if (cmd.out_load) begin
			out_vld_q  <= cmd.res.value_valid;
			out_chan_q <= cmd.res.channel;
			out_pct_q  <= cmd.res.pct_zero || !cmd.res.value_valid ? '0 : quo_q;
			out_fend_q <= cmd.res.frame_end;
			out_ovr_q  <= cmd.res.overrun_error;
			out_sync_q <= cmd.res.synced;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_pct_q, out_chan_q});
	assign m_axis_tlast  = out_fend_q;
	assign m_axis_tuser  = {out_sync_q, out_ovr_q, out_vld_q};

endmodule

// ===== src/ppm_frame_decoder.sv =====
// PPM frame decoder: one result beat for every input beat.
// A scaled channel value passes the decide, multiply, divide and done states into the output
// register; sync, overflow, overrun, ignored and empty-range beats skip multiply and divide.
// The restoring divider yields one quotient bit per cycle. A new input beat is taken only after
// the last result is loaded into the output register, which can wait on an output stall.
// Reset (arst_n low, asynchronous): registers return to 500/60/160, decoder waits for sync.
module ppm_frame_decoder
	import ppm_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input beat: tdata = pw_ticks[15:0]; tuser = func (1 = capture overflow).
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tuser,
	// Result beat: tdata = channel[3:0], percent[17:4], zeros[23:18];
	// tuser = value_valid[0], overrun_error[1], synced[2]; tlast = frame_end.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	output logic [OUT_USER_W-1:0] m_axis_tuser,
	// Register writes: 0 sync_threshold, 1 min_width, 2 max_width; index 3 is ignored.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PW_W-1:0]       cfg_data
);

	ppm_cmd_t cmd;
	ppm_sts_t sts;

	// Register writes are expected only while the decoder is idle, so they never stall.
	assign cfg_ready = 1'b1;

	// The controller owns sync state and the channel index; it classifies each
	// beat and sequences the clamp, multiply and divide steps.
	ppm_ctrl #(
		.CHANNELS(CHANNELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the registers, the scaling arithmetic and the output
	// register, which lets the next beat be taken while a result waits.
	ppm_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
